>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/b2t_pkg.sv
// ----------------------------------------------------------------------------
// b2t_pkg
// Types, codes and character tables shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package b2t_pkg;

   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] MODE_RAW   = 2'd0;
   localparam logic [1:0] MODE_ASCII = 2'd1;
   localparam logic [1:0] MODE_HEX   = 2'd2;
   localparam logic [1:0] MODE_B64   = 2'd3;

   localparam logic REG_ENCODING_MODE = 1'b0;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
   } rsp_type;

   // One unit of work for the back end: a single byte or a base64 group.
   typedef struct packed {
      logic [1:0]  mode;
      logic [23:0] group;
      logic [1:0]  nbytes;
      logic        last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] b64_char(input logic [5:0] sextet);
      logic [7:0] s;
      s = {2'b00, sextet};
      priority if (sextet < 6'd26) begin
         return s + 8'd65;
      end else if (sextet < 6'd52) begin
         return s + 8'd71;
      end else if (sextet < 6'd62) begin
         return s - 8'd4;
      end else if (sextet == 6'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] n;
      n = {4'h0, nibble};
      if (nibble < 4'd10) begin
         return n + 8'h30;
      end else begin
         return n + 8'h57;
      end
   endfunction

endpackage

`default_nettype wire

>>> src/b2t_front.sv
// ----------------------------------------------------------------------------
// b2t_front
// Accepts input beats, gathers base64 groups and pushes jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b2t_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [1:0]                mode,
   input  wire                       clear_pending,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  b2t_pkg::req_type          req_payload,
   input  b2t_pkg::queue_status_type q_status,
   output logic                      push,
   output b2t_pkg::job_type          job,
   output logic [1:0]                pending_count
);

   logic [15:0] pend_ff, pend_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        accept;
   logic [7:0]  b;
   logic        lst;

   assign req_ready     = !q_status.full;
   assign accept        = req_valid && req_ready;
   assign b             = req_payload.data_byte;
   assign lst           = req_payload.last_byte;
   assign pending_count = cnt_ff;

   always_comb begin
      pend_in    = pend_ff;
      cnt_in     = cnt_ff;
      push       = 1'b0;
      job.mode   = mode;
      job.group  = {16'h0000, b};
      job.nbytes = 2'd1;
      job.last   = lst;
      if (clear_pending) begin
         pend_in = 16'h0000;
         cnt_in  = 2'd0;
      end else if (accept) begin
         if (mode != b2t_pkg::MODE_B64) begin
            push = 1'b1;
         end else begin
            priority if (cnt_ff == 2'd2) begin
               push       = 1'b1;
               job.group  = {pend_ff, b};
               job.nbytes = 2'd3;
               cnt_in     = 2'd0;
            end else if (cnt_ff == 2'd1) begin
               if (lst) begin
                  push       = 1'b1;
                  job.group  = {pend_ff[15:8], b, 8'h00};
                  job.nbytes = 2'd2;
                  cnt_in     = 2'd0;
               end else begin
                  pend_in = {pend_ff[15:8], b};
                  cnt_in  = 2'd2;
               end
            end else begin
               if (lst) begin
                  push       = 1'b1;
                  job.group  = {b, 16'h0000};
                  job.nbytes = 2'd1;
               end else begin
                  pend_in = {b, 8'h00};
                  cnt_in  = 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 16'h0000;
         cnt_ff  <= 2'd0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> src/b2t_queue.sv
// ----------------------------------------------------------------------------
// b2t_queue
// Small job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b2t_queue #(
   parameter int DEPTH = b2t_pkg::QUEUE_DEPTH
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  b2t_pkg::job_type          push_job,
   input  wire                       pop,
   output b2t_pkg::job_type          head_job,
   output b2t_pkg::queue_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   b2t_pkg::job_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> src/b2t_back.sv
// ----------------------------------------------------------------------------
// b2t_back
// Expands queued jobs into text characters, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module b2t_back (
   input  wire                       clock,
   input  wire                       reset,
   input  b2t_pkg::job_type          job,
   input  b2t_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output b2t_pkg::rsp_type          rsp_payload
);

   logic [1:0]       idx_ff, idx_in;
   logic             valid_ff, valid_in;
   b2t_pkg::rsp_type out_ff;
   logic [7:0]       ch;
   logic [1:0]       final_idx;
   logic             load;
   logic             end_of_job;

   always_comb begin
      ch        = job.group[7:0];
      final_idx = 2'd0;
      unique case (job.mode)
         b2t_pkg::MODE_RAW: begin
            ch = job.group[7:0];
         end
         b2t_pkg::MODE_ASCII: begin
            ch = {1'b0, job.group[6:0]};
         end
         b2t_pkg::MODE_HEX: begin
            final_idx = 2'd1;
            ch = (idx_ff == 2'd0) ? b2t_pkg::hex_char(job.group[7:4])
                                  : b2t_pkg::hex_char(job.group[3:0]);
         end
         b2t_pkg::MODE_B64: begin
            final_idx = 2'd3;
            unique case (idx_ff)
               2'd0: ch = b2t_pkg::b64_char(job.group[23:18]);
               2'd1: ch = b2t_pkg::b64_char(job.group[17:12]);
               2'd2: ch = (job.nbytes >= 2'd2) ? b2t_pkg::b64_char(job.group[11:6])
                                              : b2t_pkg::PAD_CHAR;
               2'd3: ch = (job.nbytes == 2'd3) ? b2t_pkg::b64_char(job.group[5:0])
                                              : b2t_pkg::PAD_CHAR;
               default: ch = b2t_pkg::PAD_CHAR;
            endcase
         end
         default: ch = job.group[7:0];
      endcase
   end

   assign load       = !q_status.empty && (!valid_ff || rsp_ready);
   assign end_of_job = (idx_ff == final_idx);
   assign pop        = load && end_of_job;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = end_of_job ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff.out_char <= ch;
         out_ff.out_last <= job.last && end_of_job;
      end
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

>>> src/bytes_to_text_encoder_top.sv
// ----------------------------------------------------------------------------
// bytes_to_text_encoder_top
// Byte stream to text encoder with raw, ascii, hex and base64 modes.
// ----------------------------------------------------------------------------
// The result channel carries one character per cycle unless stalled, from
// a registered output stage, and that single character slot sets the rate:
// raw and ascii give one character per byte, hex two per byte, and base64
// four per group of three bytes. Input bytes are taken while earlier
// characters still wait, through a queue of QUEUE_DEPTH jobs between the
// front end and the character generator. Write encoding_mode only while
// the block is idle; a write drops any partly gathered base64 group.
`default_nettype none

`include "assert_macros.svh"

module bytes_to_text_encoder_top #(
   parameter int QUEUE_DEPTH = b2t_pkg::QUEUE_DEPTH
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  b2t_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output b2t_pkg::rsp_type                     rsp_payload,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [b2t_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire  [b2t_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [b2t_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   logic [1:0]                mode_ff, mode_in;
   logic                      csr_we;
   logic                      push;
   logic                      pop;
   b2t_pkg::job_type          push_job;
   b2t_pkg::job_type          head_job;
   b2t_pkg::queue_status_type q_status;
   logic [1:0]                pending_count;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == b2t_pkg::REG_ENCODING_MODE);
   assign mode_in    = csr_we ? csr_pwdata[1:0] : mode_ff;
   assign csr_prdata = (csr_paddr[2] == b2t_pkg::REG_ENCODING_MODE) ?
                       {{(b2t_pkg::CSR_DATA_WIDTH-2){1'b0}}, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= b2t_pkg::MODE_RAW;
      end else begin
         mode_ff <= mode_in;
      end
   end

   b2t_front u_front (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .clear_pending (csr_we),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .q_status      (q_status),
      .push          (push),
      .job           (push_job),
      .pending_count (pending_count)
   );

   b2t_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   b2t_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job         (head_job),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   `ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !q_status.full)
   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, !q_status.empty)
   `ASSERT_NEXT(a_cfg_clears_group, clock, reset, csr_we, pending_count == 2'd0)
   `ASSERT_IMPLIES(a_byte_modes_push, clock, reset,
      req_valid && req_ready && (mode_ff != b2t_pkg::MODE_B64), push)

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte buffers through bytes_to_text_encoder_top in all four text
// modes and checks every character beat against a built-in encoder model.
// Covers extreme byte values, short and full base64 groups, mode writes
// with an open group, writes to an unused register, and output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CSR_AW          = b2t_pkg::CSR_ADDR_WIDTH;
   localparam int CSR_DW          = b2t_pkg::CSR_DATA_WIDTH;
   localparam int CSR_MODE_INDEX  = 0;
   localparam int CSR_SPARE_INDEX = 1;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLDOFF_CYCLES  = 120;
   localparam int RANDOM_BYTES    = 90;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int MAX_PRINTS      = 20;

   localparam logic [8*64-1:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam logic [8*16-1:0] HEX_DIGITS = "0123456789abcdef";

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   b2t_pkg::req_type     req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   b2t_pkg::rsp_type     rsp_payload;
   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]    csr_paddr   = '0;
   logic [CSR_DW-1:0]    csr_pwdata  = '0;
   logic [CSR_DW-1:0]    csr_prdata;
   logic                 csr_pready;

   // Encoder model state.
   logic [1:0]  enc_mode    = b2t_pkg::MODE_RAW;
   logic [15:0] held_bytes  = '0;
   logic [1:0]  held_count  = '0;
   b2t_pkg::rsp_type expected_chars[$];

   int error_count   = 0;
   int bytes_sent    = 0;
   int chars_checked = 0;
   int cycle_count   = 0;

   bit sender_gaps   = 1'b0;
   int burst_left    = 0;
   int holdoff_seq   = 0;
   int holdoff_seen  = 0;
   int holdoff_left  = 0;
   int stall_pct     = 0;
   int pattern_left  = 0;

   bytes_to_text_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int want, input int got);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("mismatch: %s, expected %0h, got %0h, cycle %0d",
                  what, want, got, cycle_count);
      end
   endtask

   task automatic push_char(input logic [7:0] ch, input logic is_last);
      b2t_pkg::rsp_type c;
      c.out_char = ch;
      c.out_last = is_last;
      expected_chars.insert(expected_chars.size(), c);
   endtask

   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      return HEX_DIGITS[8*(15 - int'(nibble)) +: 8];
   endfunction

   function automatic logic [7:0] b64_digit(input logic [5:0] sextet);
      return B64_ALPHABET[8*(63 - int'(sextet)) +: 8];
   endfunction

   task automatic emit_b64_group(input logic [23:0] group, input int nbytes,
                                 input logic is_last);
      push_char(b64_digit(group[23:18]), 1'b0);
      push_char(b64_digit(group[17:12]), 1'b0);
      push_char(nbytes >= 2 ? b64_digit(group[11:6]) : b2t_pkg::PAD_CHAR, 1'b0);
      push_char(nbytes >= 3 ? b64_digit(group[5:0]) : b2t_pkg::PAD_CHAR, is_last);
   endtask

   task automatic encode_byte(input b2t_pkg::req_type item);
      logic [7:0] d;
      logic       l;
      d = item.data_byte;
      l = item.last_byte;
      case (enc_mode)
         b2t_pkg::MODE_RAW: begin
            push_char(d, l);
         end
         b2t_pkg::MODE_ASCII: begin
            push_char({1'b0, d[6:0]}, l);
         end
         b2t_pkg::MODE_HEX: begin
            push_char(hex_digit(d[7:4]), 1'b0);
            push_char(hex_digit(d[3:0]), l);
         end
         default: begin
            if (held_count == 2'd2) begin
               emit_b64_group({held_bytes, d}, 3, l);
               held_bytes = '0;
               held_count = '0;
            end else if (held_count == 2'd1) begin
               if (l) begin
                  emit_b64_group({held_bytes[15:8], d, 8'h00}, 2, 1'b1);
                  held_bytes = '0;
                  held_count = '0;
               end else begin
                  held_bytes[7:0] = d;
                  held_count = 2'd2;
               end
            end else if (l) begin
               emit_b64_group({d, 16'h0000}, 1, 1'b1);
            end else begin
               held_bytes = {d, 8'h00};
               held_count = 2'd1;
            end
         end
      endcase
   endtask

   // Checks result beats and predicts from input beats on the same edge.
   always @(posedge clock) begin : track_beats
      b2t_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected character", 0, int'(rsp_payload.out_char));
            end else begin
               want = expected_chars.pop_front();
               chars_checked++;
               if (rsp_payload.out_char !== want.out_char) begin
                  report_mismatch("out_char", int'(want.out_char),
                                  int'(rsp_payload.out_char));
               end
               if (rsp_payload.out_last !== want.out_last) begin
                  report_mismatch("out_last", int'(want.out_last),
                                  int'(rsp_payload.out_last));
               end
            end
         end
         if (req_valid && req_ready) begin
            encode_byte(req_payload);
            bytes_sent++;
         end
      end
   end

   always @(posedge clock) begin : drive_rsp_ready
      if (holdoff_seq != holdoff_seen) begin
         holdoff_seen = holdoff_seq;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(4, 40);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end else begin
            pattern_left--;
         end
         rsp_ready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic is_last);
      b2t_pkg::req_type item;
      int gap;
      item.data_byte = d;
      item.last_byte = is_last;
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input int index, input logic [CSR_DW-1:0] value);
      logic [CSR_AW-1:0] addr;
      addr = CSR_AW'(4 * index);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == CSR_MODE_INDEX) begin
         enc_mode   = value[1:0];
         held_bytes = '0;
         held_count = '0;
      end
      @(posedge clock);
   endtask

   task automatic check_mode_readback();
      logic [CSR_AW-1:0] addr;
      logic [CSR_DW-1:0] value;
      addr = CSR_AW'(4 * CSR_MODE_INDEX);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (value[1:0] !== enc_mode) begin
         report_mismatch("encoding_mode readback", int'(enc_mode), int'(value[1:0]));
      end
      @(posedge clock);
   endtask

   task automatic test_csr_access();
      check_mode_readback();
      write_csr(CSR_MODE_INDEX, CSR_DW'(b2t_pkg::MODE_B64));
      check_mode_readback();
      write_csr(CSR_SPARE_INDEX, CSR_DW'(b2t_pkg::MODE_RAW));
      check_mode_readback();
   endtask

   task automatic test_raw_and_ascii();
      write_csr(CSR_MODE_INDEX, CSR_DW'(b2t_pkg::MODE_RAW));
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_drained();
      write_csr(CSR_MODE_INDEX, CSR_DW'(b2t_pkg::MODE_ASCII));
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
      wait_drained();
   endtask

   task automatic test_hex();
      write_csr(CSR_MODE_INDEX, CSR_DW'(b2t_pkg::MODE_HEX));
      send_byte(8'h00, 1'b0);
      send_byte(8'h9A, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_base64_groups();
      write_csr(CSR_MODE_INDEX, CSR_DW'(b2t_pkg::MODE_B64));
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h4D, 1'b1);
      wait_drained();
   endtask

   task automatic test_mode_write_midstream();
      send_byte(8'h41, 1'b0);
      wait_drained();
      write_csr(CSR_MODE_INDEX, CSR_DW'(b2t_pkg::MODE_B64));
      send_byte(8'h42, 1'b0);
      send_byte(8'h43, 1'b0);
      wait_drained();
      write_csr(CSR_SPARE_INDEX, CSR_DW'(b2t_pkg::MODE_HEX));
      send_byte(8'h44, 1'b1);
      send_byte(8'h45, 1'b0);
      wait_drained();
      write_csr(CSR_MODE_INDEX, CSR_DW'(b2t_pkg::MODE_HEX));
      send_byte(8'h46, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      int i;
      sender_gaps = 1'b0;
      write_csr(CSR_MODE_INDEX, CSR_DW'(b2t_pkg::MODE_HEX));
      holdoff_seq++;
      for (i = 0; i < 24; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == 23);
      end
      wait_drained();
      write_csr(CSR_MODE_INDEX, CSR_DW'(b2t_pkg::MODE_B64));
      holdoff_seq++;
      for (i = 0; i < 18; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == 17);
      end
      wait_drained();
   endtask

   task automatic test_random_buffers();
      logic [CSR_DW-1:0] value;
      int sent;
      int buffers;
      int len;
      int b;
      int i;
      bit truncate;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         value = $urandom();
         case ($urandom_range(0, 7))
            0: value[1:0] = b2t_pkg::MODE_RAW;
            1: value[1:0] = b2t_pkg::MODE_ASCII;
            2, 3: value[1:0] = b2t_pkg::MODE_HEX;
            default: value[1:0] = b2t_pkg::MODE_B64;
         endcase
         if ($urandom_range(0, 3) == 0) begin
            write_csr(CSR_SPARE_INDEX, $urandom());
         end
         write_csr(CSR_MODE_INDEX, value);
         if ($urandom_range(0, 2) == 0) begin
            check_mode_readback();
         end
         sender_gaps = $urandom_range(0, 1);
         buffers = $urandom_range(1, 4);
         for (b = 0; b < buffers; b++) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 9);
            truncate = (b == buffers - 1) && ($urandom_range(0, 7) == 0);
            for (i = 0; i < len; i++) begin
               if (i == len - 1) begin
                  send_byte(8'($urandom_range(0, 255)), !truncate);
               end else begin
                  send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
               end
               sent++;
            end
         end
         wait_drained();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_csr_access();
      test_raw_and_ascii();
      test_hex();
      test_base64_groups();
      test_mode_write_midstream();
      test_backpressure();
      test_random_buffers();
      wait_drained();
      $display("Ran raw, ascii, hex and base64 buffers with mode writes, open groups");
      $display("and output stalls: %0d bytes in, %0d characters compared.",
               bytes_sent, chars_checked);
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
